### hw/rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FUNC_W          = 3;
  localparam int CHAR_W          = 8;
  localparam int POS_W           = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  typedef enum logic [FUNC_W-1:0] {
    FMT_SDEC = 3'd0,
    FMT_UDEC = 3'd1,
    FMT_BIN  = 3'd2,
    FMT_OCT  = 3'd3,
    FMT_HEXL = 3'd4,
    FMT_HEXU = 3'd5
  } fmt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic in_dec;
    logic neg;
    logic dabble_last;
    logic digit_zero;
    logic digit_last;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

### hw/rtl/i2a_in_if.sv
// ----------------------------------------------------------------------------
// i2a_in_if
// Input channel: format selector and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2a_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             func;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

### hw/rtl/i2a_out_if.sv
// ----------------------------------------------------------------------------
// i2a_out_if
// Output channel: one ASCII character per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic [5:0] position;
  logic       last;

  modport source (output valid, output character, output position, output last,
                  input ready);
  modport sink   (input valid, input character, input position, input last,
                  output ready);
endinterface

### hw/rtl/i2a_ctrl.sv
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: accept, BCD conversion, sign, leading zero skip, digit emission.
// ----------------------------------------------------------------------------
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic din_valid,
  output logic din_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    din_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        din_ready = 1'b1;
        if (din_valid && sts.in_ok) begin
          cmd.load   = 1'b1;
          state_next = sts.in_dec ? ST_DABBLE : ST_SKIP;
        end
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
        if (sts.dabble_last) begin
          state_next = sts.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.digit_zero && !sts.digit_last) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = sts.digit_last ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.digit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/i2a_dpath.sv
// ----------------------------------------------------------------------------
// i2a_dpath
// Magnitude and BCD shift registers, digit counter and output register.
// ----------------------------------------------------------------------------
module i2a_dpath
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [FUNC_W-1:0]      din_func,
  input  logic [VALUE_WIDTH-1:0] din_value,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   dout_valid,
  input  logic                   dout_ready,
  output logic [CHAR_W-1:0]      dout_character,
  output logic [POS_W-1:0]       dout_position,
  output logic                   dout_last
);

  localparam int W      = VALUE_WIDTH;
  localparam int ND_OCT = (W + 2) / 3;
  localparam int ND_HEX = (W + 3) / 4;
  localparam int ND_DEC = ((W * 1233) >> 12) + 1;
  localparam int MW     = (3 * ND_OCT > 4 * ND_HEX) ? 3 * ND_OCT : 4 * ND_HEX;
  localparam int BW     = 4 * ND_DEC;
  localparam int CW     = $clog2(MW + 1);
  localparam int SH_BIN = MW - W;
  localparam int SH_OCT = MW - 3 * ND_OCT;
  localparam int SH_HEX = MW - 4 * ND_HEX;

  logic [MW-1:0]    mag;
  logic [BW-1:0]    bcd;
  logic [CW-1:0]    cnt;
  fmt_t             fmt;
  logic             neg;
  logic [POS_W-1:0] pos;

  logic             in_ok;
  logic             in_neg;
  logic [W-1:0]     in_mag;
  logic [MW-1:0]    mag_init;
  logic [CW-1:0]    cnt_init;
  logic [BW-1:0]    bcd_adj;
  logic [3:0]       digit;
  logic [MW-1:0]    mag_shift;
  logic [BW-1:0]    bcd_shift;
  logic             out_free;

  assign in_ok  = (din_func <= FMT_HEXU);
  assign in_neg = (din_func == FMT_SDEC) && din_value[W-1];
  assign in_mag = in_neg ? (~din_value + {{(W-1){1'b0}}, 1'b1}) : din_value;

  always_comb begin
    mag_init = MW'(in_mag) << SH_BIN;
    cnt_init = CW'(W);
    case (din_func)
      FMT_OCT: begin
        mag_init = MW'(in_mag) << SH_OCT;
        cnt_init = CW'(ND_OCT);
      end
      FMT_HEXL, FMT_HEXU: begin
        mag_init = MW'(in_mag) << SH_HEX;
        cnt_init = CW'(ND_HEX);
      end
      default: begin
        mag_init = MW'(in_mag) << SH_BIN;
        cnt_init = CW'(W);
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < ND_DEC; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    digit     = mag[MW-1 -: 4];
    mag_shift = mag << 4;
    bcd_shift = bcd;
    case (fmt)
      FMT_BIN: begin
        digit     = {3'd0, mag[MW-1]};
        mag_shift = mag << 1;
      end
      FMT_OCT: begin
        digit     = {1'b0, mag[MW-1 -: 3]};
        mag_shift = mag << 3;
      end
      FMT_HEXL, FMT_HEXU: begin
        digit     = mag[MW-1 -: 4];
        mag_shift = mag << 4;
      end
      default: begin
        digit     = bcd[BW-1 -: 4];
        mag_shift = mag;
        bcd_shift = bcd << 4;
      end
    endcase
  end

  assign out_free = !dout_valid || dout_ready;

  always_comb begin
    sts             = '0;
    sts.in_ok       = in_ok;
    sts.in_dec      = (din_func == FMT_SDEC) || (din_func == FMT_UDEC);
    sts.neg         = neg;
    sts.dabble_last = (cnt == CW'(1));
    sts.digit_zero  = (digit == 4'd0);
    sts.digit_last  = (cnt == CW'(1));
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_init;
      bcd <= '0;
      cnt <= cnt_init;
      fmt <= fmt_t'(din_func);
      neg <= in_neg;
      pos <= '0;
    end else if (cmd.dabble) begin
      mag <= mag << 1;
      bcd <= {bcd_adj[BW-2:0], mag[MW-1]};
      cnt <= (cnt == CW'(1)) ? CW'(ND_DEC) : cnt - CW'(1);
    end else if (cmd.shift || cmd.emit_digit) begin
      mag <= mag_shift;
      bcd <= bcd_shift;
      cnt <= cnt - CW'(1);
    end
    if (cmd.emit_sign || cmd.emit_digit) begin
      pos <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      dout_valid <= 1'b1;
    end else if (dout_ready) begin
      dout_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      dout_character <= CHAR_MINUS;
      dout_position  <= pos + POS_W'(1);
      dout_last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      dout_character <= digit_char(digit, fmt == FMT_HEXU);
      dout_position  <= pos + POS_W'(1);
      dout_last      <= (cnt == CW'(1));
    end
  end

endmodule

### hw/rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Converts one value to its ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Usage:
//   din carries func (format) and value. An item is taken when the block is
//   idle; func 6 or 7 is taken and dropped without output.
//   dout gives one character per item, most significant digit first, with
//   its one-based position; last marks the final character.
// Sequence: accept, then for decimal a shift-and-add-3 BCD conversion over
//   the W = VALUE_WIDTH input bits and, for a negative signed value, the
//   minus sign; then leading zero digit slots are skipped and the remaining
//   digits are emitted. Func 6 or 7 is dropped at accept. One digit leaves
//   per cycle through the single output register while dout is ready, and
//   output stalls hold the sequencer.
// Stall: a stalled dout holds its item and the sequencer waits; the next
//   input item is taken as soon as the final character sits in the output
//   register.
// Reset: rst clears the sequencer and the output valid; the block is idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
  input  logic clk,
  input  logic rst,
  i2a_in_if.sink    din,
  i2a_out_if.source dout
);

  cmd_t cmd;
  sts_t sts;

  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .din_valid (din.valid),
    .din_ready (din.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2a_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .din_func       (din.func),
    .din_value      (din.value),
    .cmd            (cmd),
    .sts            (sts),
    .dout_valid     (dout.valid),
    .dout_ready     (dout.ready),
    .dout_character (dout.character),
    .dout_position  (dout.position),
    .dout_last      (dout.last)
  );

endmodule

### hw/rtl/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the formatter output stream.
// ----------------------------------------------------------------------------
module i2a_checker
  import i2a_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              dout_valid,
  input logic              dout_ready,
  input logic [CHAR_W-1:0] dout_character,
  input logic [POS_W-1:0]  dout_position,
  input logic              dout_last
);

  logic first;
  logic char_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (dout_valid && dout_ready) begin
      first <= dout_last;
    end
  end

  assign char_ok = (dout_character >= 8'h30 && dout_character <= 8'h39) ||
                   (dout_character >= 8'h61 && dout_character <= 8'h66) ||
                   (dout_character >= 8'h41 && dout_character <= 8'h46) ||
                   (dout_character == CHAR_MINUS);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid && $stable(dout_character) &&
      $stable(dout_position) && $stable(dout_last))
    else $error("output item changed while stalled");

  a_first_pos: assert property (@(posedge clk) disable iff (rst)
    dout_valid && first |-> dout_position == POS_W'(1))
    else $error("first character of a value not at position one");

  a_minus: assert property (@(posedge clk) disable iff (rst)
    dout_valid && dout_character == CHAR_MINUS |-> first && !dout_last)
    else $error("minus sign misplaced");

  a_char: assert property (@(posedge clk) disable iff (rst)
    dout_valid |-> char_ok)
    else $error("character outside the digit set");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .dout_valid     (dout.valid),
  .dout_ready     (dout.ready),
  .dout_character (dout.character),
  .dout_position  (dout.position),
  .dout_last      (dout.last)
);

### tb/sv/integer_to_ascii_formatter_checker.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_checker
// Watches both channels of the formatter. Each accepted value is turned into
// the text it should print, and each character item that leaves the block is
// compared field by field with the oldest character still due.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker
  import i2a_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [31:0]       in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CHAR_W-1:0] out_character,
  input  logic [POS_W-1:0]  out_position,
  input  logic              out_last,
  output int                errors,
  output int                pending,
  output int                chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  position;
    logic              last;
  } char_item_t;

  char_item_t expected_chars[$];
  int         err_count = 0;
  int         checked   = 0;

  function automatic void queue_text(input logic [FUNC_W-1:0] f, input logic [31:0] v);
    string       lower_set = "0123456789abcdef";
    string       upper_set = "0123456789ABCDEF";
    logic [31:0] mag;
    int unsigned base;
    bit          upper = 1'b0;
    bit          neg = 1'b0;
    byte unsigned digits[33];
    int          nd = 0;
    int          pos = 0;
    int          d;
    char_item_t  c;
    mag = v;
    case (f)
      FMT_SDEC, FMT_UDEC: base = 10;
      FMT_BIN:            base = 2;
      FMT_OCT:            base = 8;
      FMT_HEXL:           base = 16;
      FMT_HEXU: begin
        base  = 16;
        upper = 1'b1;
      end
      default: return;
    endcase
    if (f == FMT_SDEC && v[31]) begin
      neg = 1'b1;
      mag = -v;
    end
    do begin
      d = int'(mag % base);
      digits[nd] = upper ? upper_set[d] : lower_set[d];
      nd++;
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      pos = 1;
      c.character = CHAR_MINUS;
      c.position  = POS_W'(pos);
      c.last      = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      pos++;
      c.character = digits[k];
      c.position  = POS_W'(pos);
      c.last      = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    char_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        checked++;
        if (expected_chars.size() == 0) begin
          $error("character item with nothing due: character %h position %0d last %0b",
                 out_character, out_position, out_last);
          err_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_character);
            err_count++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            err_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) queue_text(in_func, in_value);
    end
    errors        <= err_count;
    pending       <= expected_chars.size();
    chars_checked <= checked;
  end

endmodule

### tb/sv/integer_to_ascii_formatter_core_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_tb
// Drives values in all six formats and the two unknown ones into the
// formatter, with random gaps on the input and random stalls on the output,
// including one long output stall that backs the block up. The checker
// beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_tb
  import i2a_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_BAD_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_BAD_B = 3'd7;
  localparam int                RANDOM_VALUES = 105;
  localparam int                LONG_HOLD = 400;

  logic clk;
  logic rst;
  logic no_gaps  = 1'b0;
  logic hold_req = 1'b0;
  bit   held     = 1'b0;
  int   errors;
  int   pending;
  int   chars_checked;
  int   values_sent  = 0;
  int   values_dropped = 0;

  i2a_in_if #(.VALUE_WIDTH(32)) din ();
  i2a_out_if                    dout ();

  integer_to_ascii_formatter_core #(.VALUE_WIDTH(32)) uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  integer_to_ascii_formatter_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (din.valid),
    .in_ready      (din.ready),
    .in_func       (din.func),
    .in_value      (din.value),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .out_character (dout.character),
    .out_position  (dout.position),
    .out_last      (dout.last),
    .errors        (errors),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d characters still due", pending);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      3: return -$urandom_range(1, 1000);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_value(input logic [FUNC_W-1:0] f, input logic [31:0] v);
    int gap;
    din.func  <= f;
    din.value <= v;
    din.valid <= 1'b1;
    do @(posedge clk); while (!din.ready);
    if (f == FUNC_BAD_A || f == FUNC_BAD_B) values_dropped++;
    else values_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output side: random stalls, one long hold on request
  initial begin
    int stall;
    int run;
    dout.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        dout.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout.ready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    logic [FUNC_W-1:0] f;
    int                n;
    rst       <= 1'b1;
    din.valid <= 1'b0;
    din.func  <= FMT_SDEC;
    din.value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_value(FMT_SDEC, 32'h0000_0000);
    send_value(FMT_SDEC, 32'h0000_0001);
    send_value(FMT_SDEC, 32'hFFFF_FFFF);
    send_value(FMT_SDEC, 32'h7FFF_FFFF);
    send_value(FMT_SDEC, 32'h8000_0000);
    send_value(FMT_UDEC, 32'h0000_0000);
    send_value(FMT_UDEC, 32'hFFFF_FFFF);
    send_value(FMT_UDEC, 32'd1234567890);
    send_value(FMT_BIN, 32'h0000_0000);
    send_value(FMT_BIN, 32'h0000_0001);
    send_value(FMT_BIN, 32'hFFFF_FFFF);
    send_value(FMT_BIN, 32'h8000_0000);
    send_value(FUNC_BAD_A, 32'h1234_5678);
    send_value(FMT_OCT, 32'h0000_0000);
    send_value(FMT_OCT, 32'hFFFF_FFFF);
    send_value(FMT_OCT, 32'h0000_0008);
    send_value(FMT_HEXL, 32'h0000_0000);
    send_value(FMT_HEXL, 32'hDEAD_BEEF);
    send_value(FMT_HEXL, 32'hFFFF_FFFF);
    send_value(FUNC_BAD_B, 32'hFFFF_FFFF);
    send_value(FMT_HEXU, 32'hDEAD_BEEF);
    send_value(FMT_HEXU, 32'h0000_ABCD);
    send_value(FMT_HEXU, 32'hFFFF_FFFF);

    n = 0;
    while (n < RANDOM_VALUES) begin
      no_gaps <= (n >= 40 && n < 60) || (n >= 90 && n < 102);
      if (n == 90) hold_req <= 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        f = $urandom_range(0, 1) ? FUNC_BAD_B : FUNC_BAD_A;
      end else begin
        f = FUNC_W'($urandom_range(0, 5));
        n++;
      end
      send_value(f, pick_value());
    end
    din.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Converted %0d values across six formats, dropped %0d with unknown formats,",
             values_sent, values_dropped);
    $display("checked %0d characters, with random stalls and one long output hold.",
             chars_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
